// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file pprg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, expr, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CHK_NEXT(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pprg_pkg.sv -----
// Types, constants and helper functions of the primary ray generator.
package pprg_pkg;

	localparam int COORD_FRAC_BITS = 4;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int AXIS_W    = 63;
	localparam int COMP_W    = 21;
	localparam int REG_W     = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RIGHT  = 3'd0,
		CFG_UP     = 3'd1,
		CFG_BACK   = 3'd2,
		CFG_PW     = 3'd3,
		CFG_PH     = 3'd4,
		CFG_STEP_X = 3'd5,
		CFG_STEP_Y = 3'd6
	} cfg_idx_t;

	localparam logic [AXIS_W-1:0] RIGHT_RST = 63'd262144;
	localparam logic [AXIS_W-1:0] UP_RST    = 63'd549755813888;
	localparam logic [AXIS_W-1:0] BACK_RST  = 63'd1152921504606846976;
	localparam logic [REG_W-1:0]  PLANE_RST = 31'd33554432;

	// datapath widths
	localparam int XH_W    = 18;                  // 2*coord + one, any frac width up to 8
	localparam int PRODC_W = XH_W + REG_W;        // coord times step
	localparam int ARAW_W  = PRODC_W + 2;         // exact plane coordinate, signed
	localparam int PLANE_W = 33;                  // rounded, saturated plane coordinate
	localparam int TERM_W  = PLANE_W + COMP_W;    // plane coordinate times axis component
	localparam int D_W     = TERM_W + 2;          // raw direction component, signed
	localparam int MAG_W   = D_W;
	localparam int LEN_W   = 6;
	localparam int NM_W    = 31;                  // normalized magnitude
	localparam int SQ_W    = 2 * NM_W;
	localparam int SUM_W   = 64;
	localparam int SQ_STEPS = SUM_W / 2;
	localparam int NORM_W  = 32;
	localparam int Q_W     = 19;                  // quotient, up to one in Q1.18
	localparam int NUM_W   = 52;
	localparam int DEN_W   = NORM_W + 1;
	localparam int OUT_W   = 20;
	localparam int DIR_SHIFT = 24;                // W is scaled to the 2^-42 grid

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * OUT_W;

	localparam logic [XH_W-1:0] HALF_PIX = XH_W'(1) << COORD_FRAC_BITS;
	localparam logic signed [ARAW_W-1:0] ROUND_ADD = ARAW_W'(1) << COORD_FRAC_BITS;
	localparam logic signed [ARAW_W-1:0] SAT_HI = ARAW_W'(64'sd4294967295);
	localparam logic signed [ARAW_W-1:0] SAT_LO = ARAW_W'(-64'sd4294967296);

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} side_t;

	typedef logic [2:0][NM_W-1:0] nm3_t;

	function automatic logic signed [COMP_W-1:0] axis_comp(
		input logic [AXIS_W-1:0] v, input int unsigned i);
		axis_comp = $signed(v[COMP_W*i +: COMP_W]);
	endfunction

	// round half up to 2^-24 units, then clamp to about +-256.0
	function automatic logic signed [PLANE_W-1:0] to_plane(input logic signed [ARAW_W-1:0] v);
		logic signed [ARAW_W-1:0] r;
		r = (v + ROUND_ADD) >>> (COORD_FRAC_BITS + 1);
		if (r > SAT_HI)
			r = SAT_HI;
		else if (r < SAT_LO)
			r = SAT_LO;
		to_plane = PLANE_W'(r);
	endfunction

endpackage

// ----- sv/pinhole_primary_ray_generator.sv -----
// Pinhole camera primary ray generator: pixel sample in, unit ray direction out.
// Throughput: one request per cycle unless a stall on m_tready holds the pipe; the
// 32-step square root and the 19-step divider are unrolled into one stage per step,
// so every stage takes a new item.
// A stall on m_tready freezes all stages together; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the default camera.
module pinhole_primary_ray_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pprg_pkg::IN_TDATA_W-1:0]    s_tdata,   // pixel_x[15:0], pixel_y[31:16]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pprg_pkg::OUT_TDATA_W-1:0]   m_tdata,   // dir_x[19:0], dir_y[39:20],
	                                                      // dir_z[59:40], zero pad above
	input  logic                               cfg_we,
	input  logic [pprg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pprg_pkg::AXIS_W-1:0]        cfg_data
);

	// ---------------------------------------------------------------- config
	logic [pprg_pkg::AXIS_W-1:0] right_q, up_q, back_q;
	logic [pprg_pkg::REG_W-1:0]  pw_q, ph_q, sx_q, sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= pprg_pkg::RIGHT_RST;
			up_q    <= pprg_pkg::UP_RST;
			back_q  <= pprg_pkg::BACK_RST;
			pw_q    <= pprg_pkg::PLANE_RST;
			ph_q    <= pprg_pkg::PLANE_RST;
			sx_q    <= '0;
			sy_q    <= '0;
		end else if (cfg_we) begin
			case (pprg_pkg::cfg_idx_t'(cfg_index))
				pprg_pkg::CFG_RIGHT:  right_q <= cfg_data;
				pprg_pkg::CFG_UP:     up_q    <= cfg_data;
				pprg_pkg::CFG_BACK:   back_q  <= cfg_data;
				pprg_pkg::CFG_PW:     pw_q    <= cfg_data[pprg_pkg::REG_W-1:0];
				pprg_pkg::CFG_PH:     ph_q    <= cfg_data[pprg_pkg::REG_W-1:0];
				pprg_pkg::CFG_STEP_X: sx_q    <= cfg_data[pprg_pkg::REG_W-1:0];
				pprg_pkg::CFG_STEP_Y: sy_q    <= cfg_data[pprg_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: the whole pipe moves unless the output holds an untaken result.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ------------------------------------------------- s1: coord times step
	logic                              v_s1;
	logic [pprg_pkg::PRODC_W-1:0]      xp_s1, yp_s1;
	logic [pprg_pkg::XH_W-1:0]         xh, yh;

	// (coord + 0.5) on a grid of half a subpixel
	assign xh = pprg_pkg::XH_W'({s_tdata[15:0], 1'b0}) + pprg_pkg::HALF_PIX;
	assign yh = pprg_pkg::XH_W'({s_tdata[31:16], 1'b0}) + pprg_pkg::HALF_PIX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s1 <= xh * sx_q;
			yp_s1 <= yh * sy_q;
		end
	end

	// ------------------------------------------- s2: plane coordinates a, b
	logic                                  v_s2;
	logic signed [pprg_pkg::PLANE_W-1:0]   a_s2, b_s2;
	logic [pprg_pkg::ARAW_W-1:0]           pw_sh, ph_sh;
	logic signed [pprg_pkg::ARAW_W-1:0]    a_raw, b_raw;

	assign pw_sh = pprg_pkg::ARAW_W'(pw_q) << pprg_pkg::COORD_FRAC_BITS;
	assign ph_sh = pprg_pkg::ARAW_W'(ph_q) << pprg_pkg::COORD_FRAC_BITS;
	assign a_raw = $signed(pprg_pkg::ARAW_W'(xp_s1)) - $signed(pw_sh);
	assign b_raw = $signed(ph_sh) - $signed(pprg_pkg::ARAW_W'(yp_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= pprg_pkg::to_plane(a_raw);
			b_s2 <= pprg_pkg::to_plane(b_raw);
		end
	end

	// ------------------------------------------- s3: a*U and b*V per lane
	logic                                 v_s3;
	logic signed [pprg_pkg::TERM_W-1:0]   pu_s3 [3];
	logic signed [pprg_pkg::TERM_W-1:0]   pv_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pu_s3[i] <= a_s2 * pprg_pkg::axis_comp(right_q, i);
				pv_s3[i] <= b_s2 * pprg_pkg::axis_comp(up_q, i);
			end
		end
	end

	// ------------------------------------------- s4: d = aU + bV - W, sign/magnitude
	logic                                  v_s4;
	logic [2:0]                            neg_s4;
	logic [2:0][pprg_pkg::MAG_W-1:0]       mag_s4;
	logic signed [pprg_pkg::D_W-1:0]       d_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = pprg_pkg::D_W'(pu_s3[i]) + pprg_pkg::D_W'(pv_s3[i])
				- (pprg_pkg::D_W'(pprg_pkg::axis_comp(back_q, i)) <<< pprg_pkg::DIR_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= d_c[i][pprg_pkg::D_W-1];
				mag_s4[i] <= d_c[i][pprg_pkg::D_W-1] ? pprg_pkg::MAG_W'(-d_c[i])
				                                     : pprg_pkg::MAG_W'(d_c[i]);
			end
		end
	end

	// ------------------------------------------- s5: largest magnitude
	logic                                v_s5;
	logic [2:0]                          neg_s5;
	logic [2:0][pprg_pkg::MAG_W-1:0]     mag_s5;
	logic [pprg_pkg::MAG_W-1:0]          mx_s5, mx01;

	assign mx01 = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5  <= (mx01 > mag_s4[2]) ? mx01 : mag_s4[2];
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
		end
	end

	// ------------------------------------------- s6: bit length of the largest
	logic                                v_s6;
	logic [pprg_pkg::LEN_W-1:0]          len_s6, len_c;
	logic [2:0][pprg_pkg::MAG_W-1:0]     mag_s6;
	pprg_pkg::side_t                     side_s6;

	always_comb begin
		len_c = '0;
		for (int b = 0; b < pprg_pkg::MAG_W; b++) begin
			if (mx_s5[b])
				len_c = pprg_pkg::LEN_W'(b + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s6       <= len_c;
			mag_s6       <= mag_s5;
			side_s6.neg  <= neg_s5;
			side_s6.zero <= (mx_s5 == '0);
		end
	end

	// ------------------------------------------- s7: common shift into [2^30, 2^31)
	logic                  v_s7;
	pprg_pkg::nm3_t        nm_s7, nm_c;
	pprg_pkg::side_t       side_s7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (len_s6 > pprg_pkg::LEN_W'(pprg_pkg::NM_W))
				nm_c[i] = pprg_pkg::NM_W'(mag_s6[i]
					>> (len_s6 - pprg_pkg::LEN_W'(pprg_pkg::NM_W)));
			else
				nm_c[i] = pprg_pkg::NM_W'(mag_s6[i]
					<< (pprg_pkg::LEN_W'(pprg_pkg::NM_W) - len_s6));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s7   <= nm_c;
			side_s7 <= side_s6;
		end
	end

	// ------------------------------------------- s8: squares
	logic                                v_s8;
	logic [2:0][pprg_pkg::SQ_W-1:0]      sq_s8;
	pprg_pkg::nm3_t                      nm_s8;
	pprg_pkg::side_t                     side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s8[i] <= nm_s7[i] * nm_s7[i];
			nm_s8   <= nm_s7;
			side_s8 <= side_s7;
		end
	end

	// ------------------------------------------- s9: sum of squares
	logic                          v_s9;
	logic [pprg_pkg::SUM_W-1:0]    sum_s9;
	pprg_pkg::nm3_t                nm_s9;
	pprg_pkg::side_t               side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s9  <= pprg_pkg::SUM_W'(sq_s8[0]) + pprg_pkg::SUM_W'(sq_s8[1])
			         + pprg_pkg::SUM_W'(sq_s8[2]);
			nm_s9   <= nm_s8;
			side_s9 <= side_s8;
		end
	end

	// ------------------------------------------- square root, one step per stage
	// Digit-by-digit root; the trial bit walks down from 2^62 by two places a step.
	logic                          sqv_s   [pprg_pkg::SQ_STEPS];
	logic [pprg_pkg::SUM_W-1:0]    sqn_s   [pprg_pkg::SQ_STEPS];
	logic [pprg_pkg::SUM_W-1:0]    sqr_s   [pprg_pkg::SQ_STEPS];
	pprg_pkg::nm3_t                sqnm_s  [pprg_pkg::SQ_STEPS];
	pprg_pkg::side_t               sqsd_s  [pprg_pkg::SQ_STEPS];

	for (genvar k = 0; k < pprg_pkg::SQ_STEPS; k++) begin : g_sq
		logic                          v_in;
		logic [pprg_pkg::SUM_W-1:0]    n_in, r_in, bitv;
		logic [pprg_pkg::SUM_W:0]      trial;
		pprg_pkg::nm3_t                nm_in;
		pprg_pkg::side_t               sd_in;

		if (k == 0) begin : g_first
			assign v_in  = v_s9;
			assign n_in  = sum_s9;
			assign r_in  = '0;
			assign nm_in = nm_s9;
			assign sd_in = side_s9;
		end else begin : g_next
			assign v_in  = sqv_s[k-1];
			assign n_in  = sqn_s[k-1];
			assign r_in  = sqr_s[k-1];
			assign nm_in = sqnm_s[k-1];
			assign sd_in = sqsd_s[k-1];
		end

		assign bitv  = pprg_pkg::SUM_W'(1) << (pprg_pkg::SUM_W - 2 - 2 * k);
		assign trial = {1'b0, r_in} + {1'b0, bitv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[k] <= 1'b0;
			else if (en)
				sqv_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, n_in} >= trial) begin
					sqn_s[k] <= n_in - trial[pprg_pkg::SUM_W-1:0];
					sqr_s[k] <= (r_in >> 1) + bitv;
				end else begin
					sqn_s[k] <= n_in;
					sqr_s[k] <= r_in >> 1;
				end
				sqnm_s[k] <= nm_in;
				sqsd_s[k] <= sd_in;
			end
		end
	end

	// ------------------------------------------- s10: divider set-up
	// q = floor((mag*2^19 + norm) / (2*norm)), i.e. mag/norm in Q1.18 rounded half up
	logic                                v_s10;
	logic [2:0][pprg_pkg::NUM_W-1:0]     num_s10;
	logic [pprg_pkg::DEN_W-1:0]          den_s10;
	pprg_pkg::side_t                     side_s10;
	logic [pprg_pkg::NORM_W-1:0]         norm;

	assign norm = sqr_s[pprg_pkg::SQ_STEPS-1][pprg_pkg::NORM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= sqv_s[pprg_pkg::SQ_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				num_s10[i] <= (pprg_pkg::NUM_W'(sqnm_s[pprg_pkg::SQ_STEPS-1][i]) << pprg_pkg::Q_W)
				            + pprg_pkg::NUM_W'(norm);
			den_s10  <= {norm, 1'b0};
			side_s10 <= sqsd_s[pprg_pkg::SQ_STEPS-1];
		end
	end

	// ------------------------------------------- restoring divider, one bit per stage
	logic                                dv_s  [pprg_pkg::Q_W];
	logic [2:0][pprg_pkg::NUM_W-1:0]     dr_s  [pprg_pkg::Q_W];
	logic [2:0][pprg_pkg::Q_W-1:0]       dq_s  [pprg_pkg::Q_W];
	logic [pprg_pkg::DEN_W-1:0]          dd_s  [pprg_pkg::Q_W];
	pprg_pkg::side_t                     dsd_s [pprg_pkg::Q_W];

	for (genvar j = 0; j < pprg_pkg::Q_W; j++) begin : g_div
		logic                                v_in;
		logic [2:0][pprg_pkg::NUM_W-1:0]     r_in;
		logic [2:0][pprg_pkg::Q_W-1:0]       q_in;
		logic [pprg_pkg::DEN_W-1:0]          d_in;
		pprg_pkg::side_t                     sd_in;
		logic [pprg_pkg::NUM_W-1:0]          dsh;

		if (j == 0) begin : g_first
			assign v_in  = v_s10;
			assign r_in  = num_s10;
			assign q_in  = '0;
			assign d_in  = den_s10;
			assign sd_in = side_s10;
		end else begin : g_next
			assign v_in  = dv_s[j-1];
			assign r_in  = dr_s[j-1];
			assign q_in  = dq_s[j-1];
			assign d_in  = dd_s[j-1];
			assign sd_in = dsd_s[j-1];
		end

		assign dsh = pprg_pkg::NUM_W'(d_in) << (pprg_pkg::Q_W - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[j] <= 1'b0;
			else if (en)
				dv_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (r_in[i] >= dsh) begin
						dr_s[j][i] <= r_in[i] - dsh;
						dq_s[j][i] <= q_in[i] | (pprg_pkg::Q_W'(1) << (pprg_pkg::Q_W - 1 - j));
					end else begin
						dr_s[j][i] <= r_in[i];
						dq_s[j][i] <= q_in[i];
					end
				end
				dd_s[j]  <= d_in;
				dsd_s[j] <= sd_in;
			end
		end
	end

	// ------------------------------------------- output register: sign, zero ray
	logic [2:0][pprg_pkg::OUT_W-1:0] dir_c;
	pprg_pkg::side_t                 side_o;
	logic [2:0][pprg_pkg::Q_W-1:0]   q_o;

	assign side_o = dsd_s[pprg_pkg::Q_W-1];
	assign q_o    = dq_s[pprg_pkg::Q_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_o.zero)
				dir_c[i] = '0;
			else if (side_o.neg[i])
				dir_c[i] = -pprg_pkg::OUT_W'(q_o[i]);
			else
				dir_c[i] = pprg_pkg::OUT_W'(q_o[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (en)
			m_tvalid <= dv_s[pprg_pkg::Q_W-1];
	end

	always_ff @(posedge clk) begin
		if (en)
			m_tdata <= {{pprg_pkg::OUT_PAD_W{1'b0}}, dir_c[2], dir_c[1], dir_c[0]};
	end

endmodule

// ----- sv/pprg_checker.sv -----
// Port-level checker for the primary ray generator, bound to the top level.
`include "assert_macros.svh"

module pprg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pprg_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// a result that is not taken stays as it is
	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

	// a stalled output blocks new requests
	`CHK_ALWAYS(a_stall_blocks, !(m_tvalid && !m_tready) || !s_tready, "request taken during stall")

	// padding above the three components is zero
	`CHK_ALWAYS(a_pad_zero, !m_tvalid || (m_tdata[pprg_pkg::OUT_TDATA_W-1:3*pprg_pkg::OUT_W] == '0), "nonzero pad bits")

	// the x and z unit vector components stay within [-1.0, +1.0]
	`CHK_ALWAYS(a_dx_range, !m_tvalid || ($signed(m_tdata[19:0]) >= -20'sd262144 && $signed(m_tdata[19:0]) <= 20'sd262144), "dir_x out of range")

	`CHK_ALWAYS(a_dz_range, !m_tvalid || ($signed(m_tdata[59:40]) >= -20'sd262144 && $signed(m_tdata[59:40]) <= 20'sd262144), "dir_z out of range")

endmodule

bind pinhole_primary_ray_generator pprg_checker u_pprg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/pinhole_primary_ray_generator_test.sv -----
// Self-checking testbench for the pinhole primary ray generator.
module pinhole_primary_ray_generator_test;
	import pprg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;    // pixel_x[15:0], pixel_y[31:16]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // dir_x[19:0], dir_y[39:20], dir_z[59:40]
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_RIGHT;
	logic [AXIS_W-1:0] cfg_data = '0;

	// number of registers from the input to the output of the block
	localparam int PIPE_LAT = 62;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [OUT_W-1:0] dz;
		logic signed [OUT_W-1:0] dy;
		logic signed [OUT_W-1:0] dx;
	} ray_t;

	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic        known;
		ray_t        ray;
	} pixel_row_t;

	// camera copy used by the predictor
	logic [AXIS_W-1:0] cam_u, cam_v, cam_w;
	logic [REG_W-1:0]  cam_pw, cam_ph, cam_sx, cam_sy;

	ray_t   ray_queue[$];
	int     errors = 0;
	int     rays_seen = 0;
	int     req_sent = 0;
	longint cycles = 0;
	bit     hold_off = 0;     // short random receiver bursts
	bit     long_hold = 0;    // long receiver stall
	bit     calm = 0;         // last part of the run: no idling

	pinhole_primary_ray_generator i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pinhole_primary_ray_generator_test: done, errors");
			$finish;
		end
	end

	function automatic longint comp_of(logic [AXIS_W-1:0] v, int i);
		logic signed [20:0] c;
		c = v[21*i +: 21];
		return longint'(c);
	endfunction

	// round half up to 2^-24 and clamp, from units of 2^-(F+25)
	function automatic longint snap_plane(longint v);
		longint r;
		r = (v + (64'sd1 <<< COORD_FRAC_BITS)) >>> (COORD_FRAC_BITS + 1);
		if (r > 64'sd4294967295) r = 64'sd4294967295;
		if (r < -64'sd4294967296) r = -64'sd4294967296;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic ray_t trace_dir(logic [15:0] px, logic [15:0] py);
		longint xh, yh, a, b, d;
		longint unsigned mag[3], m, sum, norm, q;
		bit neg[3];
		int len;
		logic [OUT_W-1:0] o[3];
		ray_t r;
		xh = 2 * longint'(px) + (1 << COORD_FRAC_BITS);
		yh = 2 * longint'(py) + (1 << COORD_FRAC_BITS);
		a = snap_plane(xh * longint'(cam_sx) - (longint'(cam_pw) <<< COORD_FRAC_BITS));
		b = snap_plane((longint'(cam_ph) <<< COORD_FRAC_BITS) - yh * longint'(cam_sy));
		m = 0;
		sum = 0;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			d = a * comp_of(cam_u, i) + b * comp_of(cam_v, i) - (comp_of(cam_w, i) <<< 24);
			neg[i] = d < 0;
			mag[i] = neg[i] ? longint'(-d) : longint'(d);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0)
			return '0;
		while ((m >> len) != 0) len++;
		for (int i = 0; i < 3; i++) begin
			if (len > 31) mag[i] >>= (len - 31);
			else mag[i] <<= (31 - len);
			sum += mag[i] * mag[i];
		end
		norm = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 19) + norm) / (2 * norm);
			o[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
		end
		r.dx = o[0];
		r.dy = o[1];
		r.dz = o[2];
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [AXIS_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RIGHT:  cam_u = val;
			CFG_UP:     cam_v = val;
			CFG_BACK:   cam_w = val;
			CFG_PW:     cam_pw = val[REG_W-1:0];
			CFG_PH:     cam_ph = val[REG_W-1:0];
			CFG_STEP_X: cam_sx = val[REG_W-1:0];
			default:    cam_sy = val[REG_W-1:0];
		endcase
	endtask

	function automatic logic [AXIS_W-1:0] pack_axis(int x, int y, int z);
		return {21'(z), 21'(y), 21'(x)};
	endfunction

	// offer one pixel request; expectation queued on acceptance
	task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit known, ray_t ray);
		ray_t pred;
		pred = trace_dir(px, py);
		if (known && pred !== ray) begin
			$error("table row (%0d,%0d): predictor %h, table %h", px, py, pred, ray);
			errors++;
		end
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ray_queue.push_back(known ? ray : pred);
		req_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (ray_queue.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// receiver: random stalls, short bursts and one long hold-off
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_off || long_hold || (!calm && $urandom_range(0, 9) == 0))
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	always @(negedge clk) begin
		int n;
		if (!calm && !hold_off && arst_n && $urandom_range(0, 12) == 0) begin
			n = $urandom_range(1, 18);
			hold_off = 1;
			repeat (n) @(negedge clk);
			hold_off = 0;
		end
	end

	// result checker
	always @(posedge clk) begin
		ray_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[3*OUT_W-1:0];
			rays_seen++;
			if (ray_queue.size() == 0) begin
				$error("ray with no request pending: %h", got);
				errors++;
			end else begin
				want = ray_queue.pop_front();
				if (got.dx !== want.dx) begin
					$error("dir_x expected %0d got %0d", want.dx, got.dx);
					errors++;
				end
				if (got.dy !== want.dy) begin
					$error("dir_y expected %0d got %0d", want.dy, got.dy);
					errors++;
				end
				if (got.dz !== want.dz) begin
					$error("dir_z expected %0d got %0d", want.dz, got.dz);
					errors++;
				end
			end
		end
	end

	// directed table: reset camera with zero steps gives a = -1, b = +1
	// so d = (-1, 1, -1); all rows have known=0 and use the predictor's value
	localparam ray_t ZERO_RAY = '0;
	pixel_row_t rows[] = '{
		'{16'h0000, 16'h0000, 1'b0, ZERO_RAY},
		'{16'hFFFF, 16'hFFFF, 1'b0, ZERO_RAY},
		'{16'hFFFF, 16'h0000, 1'b0, ZERO_RAY},
		'{16'h0000, 16'hFFFF, 1'b0, ZERO_RAY},
		'{16'h5555, 16'hAAAA, 1'b0, ZERO_RAY},
		'{16'hAAAA, 16'h5555, 1'b0, ZERO_RAY},
		'{16'h000F, 16'h0010, 1'b0, ZERO_RAY}
	};

	task automatic random_phase(int count, int coord_max);
		for (int k = 0; k < count; k++)
			send_pixel($urandom_range(0, coord_max), $urandom_range(0, coord_max), 0, '0);
	endtask

	initial begin
		cam_u = RIGHT_RST;
		cam_v = UP_RST;
		cam_w = BACK_RST;
		cam_pw = PLANE_RST;
		cam_ph = PLANE_RST;
		cam_sx = '0;
		cam_sy = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset camera
		foreach (rows[r]) send_pixel(rows[r].px, rows[r].py, rows[r].known, rows[r].ray);
		drain();

		// zero direction: U = V = W = 0 must give an all-zero ray
		write_reg(CFG_RIGHT, '0);
		write_reg(CFG_UP, '0);
		write_reg(CFG_BACK, '0);
		send_pixel(16'h1234, 16'h4321, 1, ZERO_RAY);
		send_pixel(16'hFFFF, 16'h0000, 1, ZERO_RAY);
		drain();

		// identity camera again, zero plane size and steps: W alone gives (0,0,-1) at center
		write_reg(CFG_RIGHT, pack_axis(1 << 18, 0, 0));
		write_reg(CFG_UP, pack_axis(0, 1 << 18, 0));
		write_reg(CFG_BACK, pack_axis(0, 0, 1 << 18));
		write_reg(CFG_PW, '0);
		write_reg(CFG_PH, '0);
		send_pixel(16'h0000, 16'h0000, 1, '{dz: -20'sd262144, dy: 20'sd0, dx: 20'sd0});
		drain();

		// extremes: max plane, max steps, saturating coordinates
		write_reg(CFG_PW, 63'h7FFFFFFF);
		write_reg(CFG_PH, 63'h7FFFFFFF);
		write_reg(CFG_STEP_X, 63'h7FFFFFFF);
		write_reg(CFG_STEP_Y, 63'h7FFFFFFF);
		foreach (rows[r]) send_pixel(rows[r].px, rows[r].py, 0, '0);
		drain();

		// extreme axes, all bits toggled
		write_reg(CFG_RIGHT, {63{1'b1}});
		write_reg(CFG_UP, pack_axis(-(1 << 20), (1 << 20) - 1, -(1 << 20)));
		write_reg(CFG_BACK, pack_axis((1 << 20) - 1, -(1 << 20), (1 << 20) - 1));
		random_phase(30, 65535);
		drain();

		// typical 640x480-ish camera, fixed tilted basis; long stall mid-phase
		write_reg(CFG_RIGHT, pack_axis(185364, 0, -185364));
		write_reg(CFG_UP, pack_axis(-107000, 214000, -107000));
		write_reg(CFG_BACK, pack_axis(151349, 151349, 151349));
		write_reg(CFG_PW, 63'd44739242);
		write_reg(CFG_PH, 63'd33554432);
		write_reg(CFG_STEP_X, 63'd69905);
		write_reg(CFG_STEP_Y, 63'd69905);
		fork
			random_phase(200, 640 * 16);
			begin
				repeat (40) @(negedge clk);
				long_hold = 1;
				repeat (300) @(negedge clk);
				long_hold = 0;
			end
		join
		drain();

		// fully random camera
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_RIGHT, AXIS_W'({$urandom, $urandom}));
			write_reg(CFG_UP, AXIS_W'({$urandom, $urandom}));
			write_reg(CFG_BACK, AXIS_W'({$urandom, $urandom}));
			write_reg(CFG_PW, $urandom);
			write_reg(CFG_PH, $urandom);
			write_reg(CFG_STEP_X, $urandom_range(0, 1 << 20));
			write_reg(CFG_STEP_Y, $urandom);
			if (p == 2) calm = 1;
			random_phase(90, 65535);
			drain();
		end

		$display("covered %0d pixel requests, %0d rays over nine camera settings",
			req_sent, rays_seen);
		if (errors == 0 && ray_queue.size() == 0)
			$display("pinhole_primary_ray_generator_test: done, clean");
		else
			$display("pinhole_primary_ray_generator_test: done, errors");
		$finish;
	end

endmodule
